// ===== rtl/core/lcu_pkg.sv =====
// ----------------------------------------------------------------------------
// Lux calculation package
// Shared widths, register indexes, coefficient tables and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package lcu_pkg;

  localparam int COUNT_W   = 16;
  localparam int LUX_W     = 29;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 2;
  localparam int COEF_W    = 10;
  localparam int SCALE_W   = 19;
  localparam int DIV_BITS  = 12;
  localparam int FRAC_SH   = 10;
  localparam int REM_W     = COUNT_W + FRAC_SH;
  localparam int PROD_W    = COUNT_W + COEF_W;
  localparam int OUT_SH    = 16;
  localparam int FULL_W    = PROD_W + SCALE_W;
  localparam int NUM_BP    = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTEG_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN_LOW   = 2'd1;

  // Integration time codes.
  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_101MS = 2'd1;
  localparam logic [1:0] INTEG_402MS = 2'd2;

  localparam logic [1:0]  INTEG_RESET   = INTEG_402MS;
  localparam logic [11:0] RATIO_FORCED  = 12'd2048;

  localparam logic [COEF_W-1:0] K_TAB_T [NUM_BP] = '{
    10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a};
  localparam logic [COEF_W-1:0] K_TAB_CS [NUM_BP] = '{
    10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a};
  localparam logic [COEF_W-1:0] B_TAB_T [NUM_BP] = '{
    10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000};
  localparam logic [COEF_W-1:0] B_TAB_CS [NUM_BP] = '{
    10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000};
  localparam logic [COEF_W-1:0] M_TAB_T [NUM_BP] = '{
    10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000};
  localparam logic [COEF_W-1:0] M_TAB_CS [NUM_BP] = '{
    10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000};

  typedef struct packed {
    logic [COUNT_W-1:0] broadband_count;
    logic [COUNT_W-1:0] infrared_count;
    logic               overflow;
    logic               bb_zero;
    logic               ir_large;
    logic [SCALE_W-1:0] scale;
  } lcu_item_t;

  function automatic logic [COUNT_W-1:0] clip_level(input logic [1:0] t);
    logic [COUNT_W-1:0] lvl;
    case (t)
      INTEG_13MS:  lvl = 16'd4900;
      INTEG_101MS: lvl = 16'd37000;
      default:     lvl = 16'd65535;
    endcase
    return lvl;
  endfunction

  function automatic logic [14:0] chan_scale(input logic [1:0] t);
    logic [14:0] s;
    case (t)
      INTEG_13MS:  s = 15'h7517;
      INTEG_101MS: s = 15'h0fe7;
      default:     s = 15'h0400;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcu_in_if.sv =====
// ----------------------------------------------------------------------------
// Lux input channel
// Carries one pair of raw sensor counts per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcu_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcu_pkg::COUNT_W-1:0] broadband_count;
  logic [lcu_pkg::COUNT_W-1:0] infrared_count;

  modport source (output valid, output broadband_count, output infrared_count,
                  input ready);
  modport sink (input valid, input broadband_count, input infrared_count,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lcu_out_if.sv =====
// ----------------------------------------------------------------------------
// Lux result channel
// Carries one lux value and its overflow flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcu_out_if;
  logic                      valid;
  logic                      ready;
  logic [lcu_pkg::LUX_W-1:0] lux_q8;
  logic                      overflow;

  modport source (output valid, output lux_q8, output overflow, input ready);
  modport sink (input valid, input lux_q8, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lcu_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Lux configuration channel
// Register write port: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcu_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lcu_pkg::CFG_IDX_W-1:0] index;
  logic [lcu_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lcu_front.sv =====
// ----------------------------------------------------------------------------
// Lux front end
// Holds the configuration registers and classifies each accepted reading pair.
// ----------------------------------------------------------------------------
`default_nettype none

module lcu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  lcu_in_if.sink             in_ch,
  lcu_cfg_if.sink            cfg_ch,
  input  wire logic          q_full,
  output logic               push,
  output lcu_pkg::lcu_item_t push_item
);

  logic [1:0]                  integ_time_r, integ_time_nxt;
  logic                        gain_low_r, gain_low_nxt;
  logic [lcu_pkg::COUNT_W-1:0] mx;
  logic [14:0]                 base_scale;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    integ_time_nxt = integ_time_r;
    gain_low_nxt   = gain_low_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        lcu_pkg::CFG_IDX_INTEG_TIME: integ_time_nxt = cfg_ch.data[1:0];
        lcu_pkg::CFG_IDX_GAIN_LOW:   gain_low_nxt   = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_time_r <= lcu_pkg::INTEG_RESET;
      gain_low_r   <= 1'b0;
    end else begin
      integ_time_r <= integ_time_nxt;
      gain_low_r   <= gain_low_nxt;
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    mx = (in_ch.broadband_count > in_ch.infrared_count) ?
         in_ch.broadband_count : in_ch.infrared_count;
    base_scale = lcu_pkg::chan_scale(integ_time_r);
    push_item.broadband_count = in_ch.broadband_count;
    push_item.infrared_count  = in_ch.infrared_count;
    push_item.overflow        = (mx >= lcu_pkg::clip_level(integ_time_r));
    push_item.bb_zero         = (in_ch.broadband_count == '0);
    push_item.ir_large        = ((in_ch.infrared_count >> 1) > in_ch.broadband_count);
    // At 1x gain the channel scale is sixteen times larger.
    push_item.scale = gain_low_r ? {base_scale, 4'b0000} : {4'b0000, base_scale};
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcu_queue.sv =====
// ----------------------------------------------------------------------------
// Lux item queue
// Small first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lcu_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lcu_pkg::lcu_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output lcu_pkg::lcu_item_t      head_item
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcu_pkg::lcu_item_t mem [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("transaction pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");

  a_fall_through: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && count_r == '0) |=> (head_valid && head_item == $past(push_item)))
    else $error("pushed item not at the head of an empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/lcu_back.sv =====
// ----------------------------------------------------------------------------
// Lux back end
// Pipelined ratio division, breakpoint select, coefficient multiply and scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module lcu_back #(
  parameter int PACKAGE_CS = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire lcu_pkg::lcu_item_t q_item,
  output logic                    q_pop,
  lcu_out_if.source               out_ch
);

  localparam int  NB    = lcu_pkg::DIV_BITS;
  localparam bit  USE_CS = (PACKAGE_CS != 0);

  // Every stage advances together; a stall at the output freezes the whole pipe.
  logic adv;

  // Division stages: one quotient bit of ir*1024/bb per stage, MSB first.
  logic                         div_vld_r  [NB];
  lcu_pkg::lcu_item_t           div_item_r [NB];
  logic [lcu_pkg::REM_W-1:0]    div_rem_r  [NB];
  logic [NB-1:0]                div_quo_r  [NB];

  logic                         div_vld_in  [NB];
  lcu_pkg::lcu_item_t           div_item_in [NB];
  logic [lcu_pkg::REM_W-1:0]    div_rem_in  [NB];
  logic [NB-1:0]                div_quo_in  [NB];

  logic                         sel_vld_r;
  lcu_pkg::lcu_item_t           sel_item_r;
  logic [2:0]                   sel_idx_r;
  logic [11:0]                  ratio;
  logic [12:0]                  ratio_rnd;
  logic [2:0]                   idx_nxt;

  logic                         mul_vld_r;
  logic                         mul_ovf_r;
  logic [lcu_pkg::SCALE_W-1:0]  mul_scale_r;
  logic [lcu_pkg::PROD_W-1:0]   pos_r, neg_r;

  logic                         dif_vld_r;
  logic                         dif_ovf_r;
  logic [lcu_pkg::SCALE_W-1:0]  dif_scale_r;
  logic [lcu_pkg::PROD_W-1:0]   diff_r;

  logic                         out_vld_r;
  logic                         out_ovf_r;
  logic [lcu_pkg::LUX_W-1:0]    out_lux_r;
  logic [lcu_pkg::FULL_W-1:0]   full_prod;

  assign adv   = !out_vld_r || out_ch.ready;
  assign q_pop = adv && q_valid;

  always_comb begin
    div_vld_in[0]  = q_valid;
    div_item_in[0] = q_item;
    div_rem_in[0]  = {q_item.infrared_count, {lcu_pkg::FRAC_SH{1'b0}}};
    div_quo_in[0]  = '0;
    for (int j = 1; j < NB; j++) begin
      div_vld_in[j]  = div_vld_r[j-1];
      div_item_in[j] = div_item_r[j-1];
      div_rem_in[j]  = div_rem_r[j-1];
      div_quo_in[j]  = div_quo_r[j-1];
    end
  end

  // The quotient only matters when ir/2 <= bb, which keeps it below 2^12,
  // so the top divisor shift is 11.
  for (genvar j = 0; j < NB; j++) begin : g_div
    localparam int SH = NB - 1 - j;
    logic [lcu_pkg::REM_W+1:0] dsh;
    logic [lcu_pkg::REM_W+1:0] rem_ext;
    logic                      ge;
    logic [lcu_pkg::REM_W-1:0] rem_nxt;
    logic [NB-1:0]             quo_nxt;

    always_comb begin
      dsh     = (lcu_pkg::REM_W + 2)'(div_item_in[j].broadband_count) << SH;
      rem_ext = {2'b00, div_rem_in[j]};
      ge      = (rem_ext >= dsh);
      rem_nxt = ge ? lcu_pkg::REM_W'(rem_ext - dsh) : div_rem_in[j];
      quo_nxt = div_quo_in[j];
      quo_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[j] <= 1'b0;
      end else if (adv) begin
        div_vld_r[j] <= div_vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_item_r[j] <= div_item_in[j];
        div_rem_r[j]  <= rem_nxt;
        div_quo_r[j]  <= quo_nxt;
      end
    end
  end

  // Rounded ratio and breakpoint select.
  always_comb begin
    ratio_rnd = {1'b0, div_quo_r[NB-1]} + 13'd1;
    if (div_item_r[NB-1].bb_zero) begin
      ratio = '0;
    end else if (div_item_r[NB-1].ir_large) begin
      ratio = lcu_pkg::RATIO_FORCED;
    end else begin
      ratio = ratio_rnd[12:1];
    end
    idx_nxt = 3'd7;
    for (int i = lcu_pkg::NUM_BP - 2; i >= 0; i--) begin
      if (ratio <= {2'b00, (USE_CS ? lcu_pkg::K_TAB_CS[i] : lcu_pkg::K_TAB_T[i])}) begin
        idx_nxt = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      dif_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      sel_vld_r <= div_vld_r[NB-1];
      mul_vld_r <= sel_vld_r;
      dif_vld_r <= mul_vld_r;
      out_vld_r <= dif_vld_r;
    end
  end

  assign full_prod = lcu_pkg::FULL_W'(diff_r) * lcu_pkg::FULL_W'(dif_scale_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_item_r <= div_item_r[NB-1];
      sel_idx_r  <= idx_nxt;

      pos_r <= lcu_pkg::PROD_W'(sel_item_r.broadband_count) *
               lcu_pkg::PROD_W'(USE_CS ? lcu_pkg::B_TAB_CS[sel_idx_r]
                                       : lcu_pkg::B_TAB_T[sel_idx_r]);
      neg_r <= lcu_pkg::PROD_W'(sel_item_r.infrared_count) *
               lcu_pkg::PROD_W'(USE_CS ? lcu_pkg::M_TAB_CS[sel_idx_r]
                                       : lcu_pkg::M_TAB_T[sel_idx_r]);
      mul_ovf_r   <= sel_item_r.overflow;
      mul_scale_r <= sel_item_r.scale;

      diff_r      <= (pos_r > neg_r) ? pos_r - neg_r : '0;
      dif_ovf_r   <= mul_ovf_r;
      dif_scale_r <= mul_scale_r;

      out_ovf_r <= dif_ovf_r;
      out_lux_r <= dif_ovf_r ? '0 :
                   full_prod[lcu_pkg::OUT_SH +: lcu_pkg::LUX_W];
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.lux_q8   = out_lux_r;
  assign out_ch.overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== rtl/core/two_channel_lux_calculation_unit.sv =====
// ----------------------------------------------------------------------------
// Two-channel lux calculation unit
// Turns broadband and infrared sensor counts into lux with 8 fractional bits.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one broadband/infrared count pair per transaction,
// out_ch returns one lux_q8/overflow result per input transaction, in order.
// cfg_ch writes integration_time (index 0) and gain_is_low (index 1); it is
// always ready and should only be written while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver holds ready high;
// a low ready stalls the pipe. The back end is the 12-stage ratio divider
// (one quotient bit per stage) and four stages for breakpoint select,
// coefficient multiply, clamp and scale multiply.
// Front end and back end are joined by a QUEUE_DEPTH entry queue. When the
// receiver holds ready low the whole back pipeline freezes, the queue fills,
// and in_ch.ready drops once it is full. Reset empties the queue and the
// pipeline and sets integration time to 402 ms at high gain.
// ----------------------------------------------------------------------------
`default_nettype none

module two_channel_lux_calculation_unit #(
  parameter int PACKAGE_CS  = 0,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lcu_in_if.sink    in_ch,
  lcu_out_if.source out_ch,
  lcu_cfg_if.sink   cfg_ch
);

  logic               push;
  lcu_pkg::lcu_item_t push_item;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  lcu_pkg::lcu_item_t q_item;

  lcu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  lcu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  lcu_back #(
    .PACKAGE_CS (PACKAGE_CS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lux calculation unit testbench
// Drives count pairs through the input channel under several integration
// time and gain settings, predicts each lux result and overflow flag, and
// checks every result in order while both channels idle at random.
// ----------------------------------------------------------------------------

module testbench;
  import lcu_pkg::*;

  localparam int PKG_CS        = 0;
  localparam int NUM_PHASES    = 9;
  localparam int PHASE_ITEMS   = 86;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  // Code 3 is not named in the package; it behaves as the 402 ms setting.
  localparam logic [1:0] INTEG_402MS_ALT = 2'd3;

  localparam logic [COUNT_W-1:0] CLIP_13MS  = 16'd4900;
  localparam logic [COUNT_W-1:0] CLIP_101MS = 16'd37000;
  localparam logic [COUNT_W-1:0] CLIP_402MS = 16'd65535;
  localparam logic [14:0] SCALE_13MS  = 15'h7517;
  localparam logic [14:0] SCALE_101MS = 15'h0fe7;
  localparam logic [14:0] SCALE_402MS = 15'h0400;

  localparam logic [CFG_DAT_W-1:0] PHASE_INTEG [NUM_PHASES] = '{
    INTEG_13MS, INTEG_13MS, INTEG_101MS, INTEG_101MS, INTEG_402MS_ALT,
    INTEG_402MS, INTEG_402MS_ALT, INTEG_13MS, INTEG_402MS};
  localparam logic [CFG_DAT_W-1:0] PHASE_GAIN [NUM_PHASES] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0};

  typedef struct packed {
    logic [COUNT_W-1:0] broadband_count;
    logic [COUNT_W-1:0] infrared_count;
  } count_pair_t;

  typedef struct packed {
    logic [LUX_W-1:0] lux_q8;
    logic             overflow;
  } lux_result_t;

  logic clk = 1'b0;
  logic rst_n;

  lcu_in_if  in_if ();
  lcu_out_if out_if ();
  lcu_cfg_if cfg_if ();

  two_channel_lux_calculation_unit #(
    .PACKAGE_CS(PKG_CS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  count_pair_t pending_pairs [$];
  lux_result_t expected_lux [$];

  logic [1:0] integ_cfg;
  logic       gain_low_cfg;
  logic       quiet_tail;
  int         hold_asked;
  int         hold_taken;
  int         failures;
  int         items_accepted;
  int         results_checked;
  int         overflows_seen;
  int         input_stall_cycles;
  int         settings_used;

  function automatic logic [COUNT_W-1:0] clip_for(input logic [1:0] integ);
    case (integ)
      INTEG_13MS:  return CLIP_13MS;
      INTEG_101MS: return CLIP_101MS;
      default:     return CLIP_402MS;
    endcase
  endfunction

  function automatic lux_result_t predict_lux(input count_pair_t p, input logic [1:0] integ,
                                              input logic gain_low);
    logic [COUNT_W-1:0] peak;
    logic [31:0]        ratio;
    logic [63:0]        pos;
    logic [63:0]        neg;
    logic [63:0]        diff;
    logic [63:0]        scale;
    logic [63:0]        full;
    int                 sel;
    lux_result_t        r;
    r.lux_q8   = '0;
    r.overflow = 1'b0;
    peak = (p.broadband_count > p.infrared_count) ? p.broadband_count : p.infrared_count;
    if (peak >= clip_for(integ)) begin
      r.overflow = 1'b1;
      return r;
    end
    ratio = 32'd0;
    if (p.broadband_count != 0) begin
      ratio = (((32'(p.infrared_count) << FRAC_SH) / 32'(p.broadband_count)) + 32'd1) >> 1;
      if ((p.infrared_count >> 1) > p.broadband_count)
        ratio = 32'(RATIO_FORCED);
    end
    // Lowest breakpoint that the ratio does not exceed; the last one catches the rest.
    sel = NUM_BP - 1;
    for (int i = NUM_BP - 2; i >= 0; i--)
      if (ratio <= 32'((PKG_CS != 0) ? K_TAB_CS[i] : K_TAB_T[i]))
        sel = i;
    pos  = 64'(p.broadband_count) * 64'((PKG_CS != 0) ? B_TAB_CS[sel] : B_TAB_T[sel]);
    neg  = 64'(p.infrared_count) * 64'((PKG_CS != 0) ? M_TAB_CS[sel] : M_TAB_T[sel]);
    diff = (pos > neg) ? pos - neg : 64'd0;
    case (integ)
      INTEG_13MS:  scale = 64'(SCALE_13MS);
      INTEG_101MS: scale = 64'(SCALE_101MS);
      default:     scale = 64'(SCALE_402MS);
    endcase
    if (gain_low)
      scale = scale << 4;
    full = diff * scale;
    r.lux_q8 = full[OUT_SH +: LUX_W];
    return r;
  endfunction

  // Most pairs sit below the clip level with a spread of ratios across all
  // breakpoints; the rest are near the clip level, tiny, zero or fully random.
  function automatic count_pair_t random_pair(input logic [1:0] integ);
    int          mode;
    int          clip;
    int          bb;
    int          ir;
    int          m;
    int          k;
    count_pair_t p;
    clip = int'(clip_for(integ));
    mode = $urandom_range(0, 9);
    case (mode)
      0: begin
        bb = $urandom_range(0, 65535);
        ir = $urandom_range(0, 65535);
      end
      1: begin
        bb = clip - 2 + $urandom_range(0, 3);
        ir = $urandom_range(0, clip - 1);
        if (bb > 65535) bb = 65535;
        if ($urandom_range(0, 1) == 1) begin
          m  = bb;
          bb = ir;
          ir = m;
        end
      end
      7: begin
        bb = $urandom_range(0, 15);
        ir = $urandom_range(0, 15);
      end
      8: begin
        m  = $urandom_range(1, 8);
        k  = $urandom_range(0, NUM_BP - 2);
        bb = 512 * m;
        ir = int'(K_TAB_T[k]) * m + $urandom_range(0, 2 * m) - m;
      end
      9: begin
        bb = $urandom_range(0, 1) ? 0 : $urandom_range(1, clip - 1);
        ir = (bb == 0) ? $urandom_range(0, clip - 1) : 0;
      end
      default: begin
        bb = $urandom_range(1, clip - 1);
        ir = (bb * $urandom_range(0, 1400)) / 1024;
      end
    endcase
    if (ir > 65535) ir = 65535;
    if (ir < 0) ir = 0;
    p.broadband_count = bb[COUNT_W-1:0];
    p.infrared_count  = ir[COUNT_W-1:0];
    return p;
  endfunction

  // Input driver: presents queued pairs and records the prediction of each
  // accepted transaction.
  int send_gap;
  count_pair_t next_pair;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && !in_if.ready)
        input_stall_cycles++;
      if (in_if.valid && in_if.ready) begin
        next_pair.broadband_count = in_if.broadband_count;
        next_pair.infrared_count  = in_if.infrared_count;
        expected_lux.push_back(predict_lux(next_pair, integ_cfg, gain_low_cfg));
        items_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0)
          send_gap--;
        else if (!quiet_tail && $urandom_range(0, 11) == 0)
          send_gap = $urandom_range(1, 6);
        if (send_gap == 0 && pending_pairs.size() != 0) begin
          next_pair = pending_pairs.pop_front();
          in_if.valid           <= 1'b1;
          in_if.broadband_count <= next_pair.broadband_count;
          in_if.infrared_count  <= next_pair.infrared_count;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random short stalls plus the long hold-off on request.
  int stall_left;
  int hold_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_left > 0)
        hold_left--;
      else if (hold_taken != hold_asked) begin
        hold_taken++;
        hold_left = LONG_HOLD;
      end else if (stall_left > 0)
        stall_left--;
      else if (!quiet_tail && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 6);
      out_if.ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  // Result monitor.
  lux_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_lux.size() == 0) begin
        $error("result with no transaction pending: lux_q8 %0d, overflow %0b",
               out_if.lux_q8, out_if.overflow);
        failures++;
      end else begin
        want = expected_lux.pop_front();
        results_checked++;
        if (want.overflow)
          overflows_seen++;
        if (out_if.lux_q8 !== want.lux_q8) begin
          $error("lux_q8 mismatch: expected %0d, actual %0d", want.lux_q8, out_if.lux_q8);
          failures++;
        end
        if (out_if.overflow !== want.overflow) begin
          $error("overflow mismatch: expected %0b, actual %0b", want.overflow, out_if.overflow);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic push_pair(input int bb, input int ir);
    count_pair_t p;
    p.broadband_count = bb[COUNT_W-1:0];
    p.infrared_count  = ir[COUNT_W-1:0];
    pending_pairs.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_IDX_INTEG_TIME)
      integ_cfg = data;
    else if (idx == CFG_IDX_GAIN_LOW)
      gain_low_cfg = data[0];
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || in_if.valid || expected_lux.size() != 0);
  endtask

  int boundary_ir [12] = '{64, 65, 128, 192, 256, 312, 410, 666, 667, 1024, 1025, 1026};

  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.broadband_count = '0;
    in_if.infrared_count  = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    integ_cfg             = INTEG_RESET;
    gain_low_cfg          = 1'b0;
    quiet_tail            = 1'b0;
    hold_asked            = 0;
    hold_taken            = 0;
    failures              = 0;
    items_accepted        = 0;
    results_checked       = 0;
    overflows_seen        = 0;
    input_stall_cycles    = 0;
    settings_used         = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs under the reset setting: zero counts, clip edges, forced
    // ratio, and each breakpoint hit exactly, the first and last also just past
    // (bb = 512 makes the ratio equal to ir).
    push_pair(0, 0);
    push_pair(0, 100);
    push_pair(0, 65535);
    push_pair(65535, 0);
    push_pair(65534, 0);
    push_pair(100, 250);
    push_pair(1, 0);
    push_pair(1, 3);
    push_pair(65534, 65534);
    push_pair(65534, 1000);
    foreach (boundary_ir[i])
      push_pair(512, boundary_ir[i]);
    repeat (60)
      pending_pairs.push_back(random_pair(integ_cfg));
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_IDX_INTEG_TIME, PHASE_INTEG[ph]);
      write_reg(CFG_IDX_GAIN_LOW, PHASE_GAIN[ph]);
      settings_used++;
      @(negedge clk);
      if (ph == 2)
        hold_asked++;
      if (ph == NUM_PHASES - 1)
        quiet_tail = 1'b1;
      repeat (PHASE_ITEMS)
        pending_pairs.push_back(random_pair(integ_cfg));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_lux.size() != 0) begin
      $error("%0d expected results never arrived", expected_lux.size());
      failures++;
    end
    $display("Ran %0d count pairs over %0d register settings; %0d results checked, %0d overflows.",
             items_accepted, settings_used, results_checked, overflows_seen);
    $display("Receiver held off %0d time(s); input channel stalled for %0d cycles.",
             hold_taken, input_stall_cycles);
    if (failures == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
